/* sv/ssrm_pkg.sv */
`timescale 1ns / 1ps
package ssrm_pkg;
    localparam int COUNT_BITS_DEF     = 16;
    localparam int SUM_BITS_DEF       = 32;
    localparam int DIFF_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam logic [30:0] CUTOFF_RESET = 31'd10737418;

    typedef enum logic [1:0] {
        t_div_idle,
        t_div_run,
        t_div_done
    } t_div_state;
endpackage

/* sv/significant_site_region_merger.sv */
`timescale 1ns / 1ps
// An item that closes a region shows its result once the bit-serial ratio dividers
// have finished with that region.
// The block accepts one site per cycle while the region queue has room; emitted
// regions drain one at a time, each only after its divide and its pop.
// Reset (synchronous, active low) closes the open region, empties the queue
// and restores the cutoff to about 0.01.
module significant_site_region_merger
    import ssrm_pkg::*;
#(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int SUM_BITS       = SUM_BITS_DEF,
    parameter int DIFF_FRAC_BITS = DIFF_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_end_of_stream,
    input  logic [7:0]         i_chrom_code,
    input  logic [31:0]        i_site_position,
    input  logic signed [31:0] i_raw_pvalue,
    input  logic signed [31:0] i_corrected_pvalue,
    input  logic [15:0]        i_test_coverage,
    input  logic [15:0]        i_test_methylated,
    input  logic [15:0]        i_rest_coverage,
    input  logic [15:0]        i_rest_methylated,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_region_chrom,
    output logic [31:0]        o_region_start,
    output logic [31:0]        o_region_end,
    output logic [15:0]        o_raw_significant_count,
    output logic [31:0]        o_test_coverage_sum,
    output logic [31:0]        o_test_methylated_sum,
    output logic [31:0]        o_rest_coverage_sum,
    output logic [31:0]        o_rest_methylated_sum,
    output logic signed [17:0] o_level_difference,
    output logic               o_zero_coverage
);
    localparam int QWIDTH = 8 + 32 + 32 + COUNT_BITS + 4 * SUM_BITS;

    logic [30:0]           r_cutoff;
    logic                  w_emit, w_qfull, w_qempty, w_take;
    logic [7:0]            w_chrom, w_qchrom;
    logic [31:0]           w_start, w_end, w_qstart, w_qend;
    logic [COUNT_BITS-1:0] w_count, w_qcount;
    logic [SUM_BITS-1:0]   w_sum [4];
    logic [SUM_BITS-1:0]   w_qsum [4];
    logic [QWIDTH-1:0]     w_qin, w_qout;

    // The cutoff register takes every transfer on the configuration channel.
    assign cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (cfg_valid) begin
            r_cutoff <= i_cfg_data;
        end
    end

    ssrm_front #(.COUNT_BITS(COUNT_BITS), .SUM_BITS(SUM_BITS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_cutoff(r_cutoff),
        .i_end_of_stream, .i_chrom_code, .i_site_position, .i_raw_pvalue,
        .i_corrected_pvalue, .i_test_coverage, .i_test_methylated,
        .i_rest_coverage, .i_rest_methylated,
        .o_emit(w_emit), .i_queue_full(w_qfull), .o_chrom(w_chrom),
        .o_start(w_start), .o_end(w_end), .o_count(w_count), .o_sum(w_sum)
    );

    // Closed regions wait here so that merging stalls on the dividers only when the queue is full.
    assign w_qin = {w_chrom, w_start, w_end, w_count, w_sum[0], w_sum[1], w_sum[2], w_sum[3]};
    assign {w_qchrom, w_qstart, w_qend, w_qcount, w_qsum[0], w_qsum[1], w_qsum[2], w_qsum[3]}
        = w_qout;

    ssrm_queue #(.WIDTH(QWIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_emit), .i_data(w_qin), .o_full(w_qfull),
        .i_pop(w_take), .o_empty(w_qempty), .o_data(w_qout)
    );

    ssrm_back #(
        .COUNT_BITS(COUNT_BITS), .SUM_BITS(SUM_BITS), .DIFF_FRAC_BITS(DIFF_FRAC_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_valid(!w_qempty), .o_take(w_take),
        .i_chrom(w_qchrom), .i_start(w_qstart), .i_end(w_qend),
        .i_count(w_qcount), .i_sum(w_qsum), .o_empty(empty), .i_pop(pop),
        .o_region_chrom, .o_region_start, .o_region_end, .o_raw_significant_count,
        .o_test_coverage_sum, .o_test_methylated_sum, .o_rest_coverage_sum,
        .o_rest_methylated_sum, .o_level_difference, .o_zero_coverage
    );
endmodule

/* sv/ssrm_front.sv */
`timescale 1ns / 1ps
module ssrm_front
    import ssrm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int SUM_BITS   = SUM_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [30:0]           i_cutoff,
    input  logic                  i_end_of_stream,
    input  logic [7:0]            i_chrom_code,
    input  logic [31:0]           i_site_position,
    input  logic signed [31:0]    i_raw_pvalue,
    input  logic signed [31:0]    i_corrected_pvalue,
    input  logic [15:0]           i_test_coverage,
    input  logic [15:0]           i_test_methylated,
    input  logic [15:0]           i_rest_coverage,
    input  logic [15:0]           i_rest_methylated,
    // Region descriptor handed to the queue.
    output logic                  o_emit,
    input  logic                  i_queue_full,
    output logic [7:0]            o_chrom,
    output logic [31:0]           o_start,
    output logic [31:0]           o_end,
    output logic [COUNT_BITS-1:0] o_count,
    output logic [SUM_BITS-1:0]   o_sum [4]
);
    logic                  r_open, n_open;
    logic                  r_skip, n_skip;
    logic [7:0]            r_chrom;
    logic [31:0]           r_start, r_end;
    logic [COUNT_BITS-1:0] r_count;
    logic [SUM_BITS-1:0]   r_sum [4];
    logic [15:0]           w_cnt [4];
    logic                  w_accept, w_sig, w_rawsig, w_extend, w_emit_now;
    logic [SUM_BITS:0]     w_add [4];
    logic [COUNT_BITS:0]   w_cadd;

    assign w_cnt[0] = i_test_coverage;
    assign w_cnt[1] = i_test_methylated;
    assign w_cnt[2] = i_rest_coverage;
    assign w_cnt[3] = i_rest_methylated;

    // The merge decision is combinational; stall only when the queue is full.
    assign o_full   = i_queue_full;
    assign w_accept = i_push && !i_queue_full;
    assign w_sig    = !i_corrected_pvalue[31]
                      && ($unsigned(i_corrected_pvalue[30:0]) < i_cutoff);
    assign w_rawsig = !i_raw_pvalue[31] && ($unsigned(i_raw_pvalue[30:0]) < i_cutoff);
    assign w_extend = r_open && !r_skip && (i_chrom_code == r_chrom);
    assign w_emit_now = r_open && (r_count != '0)
                        && (i_end_of_stream || (w_sig && !w_extend));
    assign o_emit   = w_accept && w_emit_now;
    assign o_chrom  = r_chrom;
    assign o_start  = r_start;
    assign o_end    = r_end;
    assign o_count  = r_count;
    assign o_sum    = r_sum;
    assign w_cadd   = {1'b0, r_count} + (COUNT_BITS + 1)'(w_rawsig);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_add[k] = {1'b0, r_sum[k]} + (SUM_BITS + 1)'(w_cnt[k]);
        end
        n_open = r_open;
        n_skip = r_skip;
        if (w_accept) begin
            if (i_end_of_stream) begin
                n_open = 1'b0;
                n_skip = 1'b0;
            end else if (!w_sig) begin
                n_skip = 1'b1;
            end else begin
                n_open = 1'b1;
                n_skip = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_skip <= 1'b0;
        end else begin
            r_open <= n_open;
            r_skip <= n_skip;
        end
        if (w_accept && !i_end_of_stream && w_sig) begin
            r_end <= i_site_position + 32'd1;
            if (w_extend) begin
                r_count <= w_cadd[COUNT_BITS] ? '1 : w_cadd[COUNT_BITS-1:0];
                for (int k = 0; k < 4; k++) begin
                    r_sum[k] <= w_add[k][SUM_BITS] ? '1 : w_add[k][SUM_BITS-1:0];
                end
            end else begin
                r_chrom <= i_chrom_code;
                r_start <= i_site_position;
                r_count <= COUNT_BITS'(w_rawsig);
                for (int k = 0; k < 4; k++) begin
                    r_sum[k] <= SUM_BITS'(w_cnt[k]);
                end
            end
        end
    end
endmodule

/* sv/ssrm_queue.sv */
`timescale 1ns / 1ps
module ssrm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW + 1)'(w_push) - (AW + 1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

/* sv/ssrm_back.sv */
`timescale 1ns / 1ps
module ssrm_back
    import ssrm_pkg::*;
#(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int SUM_BITS       = SUM_BITS_DEF,
    parameter int DIFF_FRAC_BITS = DIFF_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_take,
    input  logic [7:0]                i_chrom,
    input  logic [31:0]               i_start,
    input  logic [31:0]               i_end,
    input  logic [COUNT_BITS-1:0]     i_count,
    input  logic [SUM_BITS-1:0]       i_sum [4],
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [7:0]                o_region_chrom,
    output logic [31:0]               o_region_start,
    output logic [31:0]               o_region_end,
    output logic [15:0]               o_raw_significant_count,
    output logic [31:0]               o_test_coverage_sum,
    output logic [31:0]               o_test_methylated_sum,
    output logic [31:0]               o_rest_coverage_sum,
    output logic [31:0]               o_rest_methylated_sum,
    output logic signed [17:0]        o_level_difference,
    output logic                      o_zero_coverage
);
    localparam int SW = (DIFF_FRAC_BITS > 1) ? $clog2(DIFF_FRAC_BITS + 1) : 1;
    localparam int QW = DIFF_FRAC_BITS + 1;

    t_div_state          r_state, n_state;
    logic [SW-1:0]       r_step;
    logic [SUM_BITS:0]   r_rem_a, r_rem_b;
    logic [SUM_BITS-1:0] r_div_a, r_div_b;
    logic [QW-1:0]       r_q_a, r_q_b;
    logic                r_zero;
    logic [SUM_BITS:0]   w_sh_a, w_sh_b;
    logic                w_ge_a, w_ge_b;
    logic [QW:0]         w_diff;

    // Two restoring dividers run side by side, one quotient bit per cycle.
    assign w_sh_a = {r_rem_a[SUM_BITS-1:0], 1'b0};
    assign w_sh_b = {r_rem_b[SUM_BITS-1:0], 1'b0};
    assign w_ge_a = w_sh_a >= {1'b0, r_div_a};
    assign w_ge_b = w_sh_b >= {1'b0, r_div_b};
    assign w_diff = {1'b0, r_q_a} - {1'b0, r_q_b};

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_div_idle: if (i_valid) n_state = t_div_run;
            t_div_run:  if (r_step == SW'(DIFF_FRAC_BITS)) n_state = t_div_done;
            t_div_done: if (i_pop) n_state = t_div_idle;
            default:    n_state = t_div_idle;
        endcase
    end

    always_comb begin
        o_take  = (r_state == t_div_idle) && i_valid;
        o_empty = (r_state != t_div_done);
        o_level_difference = r_zero ? '0 : 18'(w_diff);
        o_zero_coverage    = r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_div_idle;
        end else begin
            r_state <= n_state;
        end
        if (o_take) begin
            o_region_chrom          <= i_chrom;
            o_region_start          <= i_start;
            o_region_end            <= i_end;
            o_raw_significant_count <= 16'(i_count);
            o_test_coverage_sum     <= 32'(i_sum[0]);
            o_test_methylated_sum   <= 32'(i_sum[1]);
            o_rest_coverage_sum     <= 32'(i_sum[2]);
            o_rest_methylated_sum   <= 32'(i_sum[3]);
            r_zero  <= (i_sum[0] == '0) || (i_sum[2] == '0);
            r_step  <= '0;
            r_div_a <= i_sum[0];
            r_div_b <= i_sum[2];
            r_rem_a <= {1'b0, i_sum[1]};
            r_rem_b <= {1'b0, i_sum[3]};
            r_q_a   <= (i_sum[1] >= i_sum[0]) ? QW'(1) << DIFF_FRAC_BITS : '0;
            r_q_b   <= (i_sum[3] >= i_sum[2]) ? QW'(1) << DIFF_FRAC_BITS : '0;
        end else if (r_state == t_div_run && r_step != SW'(DIFF_FRAC_BITS)) begin
            r_step <= r_step + SW'(1);
            if (!r_q_a[DIFF_FRAC_BITS]) begin
                r_rem_a <= w_ge_a ? w_sh_a - {1'b0, r_div_a} : w_sh_a;
                r_q_a   <= {r_q_a[QW-2:0], w_ge_a};
            end
            if (!r_q_b[DIFF_FRAC_BITS]) begin
                r_rem_b <= w_ge_b ? w_sh_b - {1'b0, r_div_b} : w_sh_b;
                r_q_b   <= {r_q_b[QW-2:0], w_ge_b};
            end
        end
    end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Region merger regression. Site records and end-of-stream marks are pushed
// into the block while a predictor tracks the open region and queues the
// region it expects to see emitted. The monitor pops results and compares
// every field with the oldest queued region.
module testbench
    import ssrm_pkg::*;
;

    typedef struct packed {
        logic        eos;
        logic [7:0]  chrom;
        logic [31:0] pos;
        logic [31:0] rawp;
        logic [31:0] corp;
        logic [15:0] tcov;
        logic [15:0] tmeth;
        logic [15:0] rcov;
        logic [15:0] rmeth;
    } t_site;

    typedef struct packed {
        logic [7:0]  chrom;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic [15:0] raw_count;
        logic [31:0] tcov;
        logic [31:0] tmeth;
        logic [31:0] rcov;
        logic [31:0] rmeth;
        logic [17:0] diff;
        logic        zero_cov;
    } t_region;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SITE_BITS = $bits(t_site);

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic cfg_valid = 0;
    logic [30:0] cfg_data = '0;
    logic full, empty, cfg_ready;
    t_site drv = '0;
    t_region seen;

    t_site   pending_sites[$];
    t_region expected_regions[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      quiet_tail = 0;
    bit      hold_receiver = 0;
    int      hold_count = 0;
    int      push_gap = 0;
    int      pop_gap = 0;

    // Predictor state: the cutoff and the region being built.
    logic [30:0] cutoff;
    bit          reg_open, skipped;
    t_region     open_reg;

    significant_site_region_merger uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_end_of_stream(drv.eos), .i_chrom_code(drv.chrom),
        .i_site_position(drv.pos), .i_raw_pvalue(drv.rawp),
        .i_corrected_pvalue(drv.corp), .i_test_coverage(drv.tcov),
        .i_test_methylated(drv.tmeth), .i_rest_coverage(drv.rcov),
        .i_rest_methylated(drv.rmeth), .empty(empty), .pop(pop),
        .o_region_chrom(seen.chrom), .o_region_start(seen.start_pos),
        .o_region_end(seen.end_pos), .o_raw_significant_count(seen.raw_count),
        .o_test_coverage_sum(seen.tcov), .o_test_methylated_sum(seen.tmeth),
        .o_rest_coverage_sum(seen.rcov), .o_rest_methylated_sum(seen.rmeth),
        .o_level_difference(seen.diff), .o_zero_coverage(seen.zero_cov)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Methylation ratio in Q.16, truncated, pinned at 1.0.
    function automatic logic [17:0] meth_ratio(logic [31:0] m, logic [31:0] c);
        logic [47:0] q;
        if (m >= c) return 18'h10000;
        q = {m, 16'h0} / c;
        return q[17:0];
    endfunction

    function automatic bit below_cutoff(logic [31:0] p);
        return !p[31] && (p < {1'b0, cutoff});
    endfunction

    task automatic flush_region();
        t_region r;
        if (!reg_open || open_reg.raw_count == 0) return;
        r = open_reg;
        if (r.tcov == 0 || r.rcov == 0) begin
            r.zero_cov = 1;
            r.diff = '0;
        end else begin
            r.zero_cov = 0;
            r.diff = meth_ratio(r.tmeth, r.tcov) - meth_ratio(r.rmeth, r.rcov);
        end
        expected_regions.push_back(r);
    endtask

    task automatic predict_site(t_site s);
        bit rawsig;
        if (s.eos) begin
            flush_region();
            reg_open = 0;
            skipped = 0;
            return;
        end
        if (!below_cutoff(s.corp)) begin
            skipped = 1;
            return;
        end
        rawsig = below_cutoff(s.rawp);
        if (reg_open && !skipped && s.chrom == open_reg.chrom) begin
            open_reg.end_pos = s.pos + 1;
            if (rawsig && open_reg.raw_count != 16'hFFFF)
                open_reg.raw_count++;
            open_reg.tcov = sat_sum(open_reg.tcov, s.tcov);
            open_reg.tmeth = sat_sum(open_reg.tmeth, s.tmeth);
            open_reg.rcov = sat_sum(open_reg.rcov, s.rcov);
            open_reg.rmeth = sat_sum(open_reg.rmeth, s.rmeth);
        end else begin
            flush_region();
            reg_open = 1;
            open_reg = '0;
            open_reg.chrom = s.chrom;
            open_reg.start_pos = s.pos;
            open_reg.end_pos = s.pos + 1;
            open_reg.raw_count = rawsig;
            open_reg.tcov = s.tcov;
            open_reg.tmeth = s.tmeth;
            open_reg.rcov = s.rcov;
            open_reg.rmeth = s.rmeth;
        end
        skipped = 0;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Driver: pushes the next pending site and feeds the predictor on each
    // accepted transfer. Random gaps are suppressed in the quiet tail.
    always @(posedge i_clk) begin
        if (push && !full) begin
            predict_site(drv);
        end
        if (push && full) begin
            // Hold the offered item until the block takes it.
        end else if (push_gap > 0) begin
            push_gap <= push_gap - 1;
            push <= 0;
        end else if (pending_sites.size() > 0 &&
                     !quiet_tail && $urandom_range(0, 9) == 0) begin
            push_gap <= $urandom_range(1, 11) - 1;
            push <= 0;
        end else if (pending_sites.size() > 0) begin
            drv <= pending_sites.pop_front();
            push <= 1;
        end else begin
            push <= 0;
        end
    end

    // Monitor: pops results and checks them against the oldest expectation.
    always @(posedge i_clk) begin
        t_region want;
        if (pop && !empty) begin
            if (expected_regions.size() == 0) begin
                report_mismatch("unexpected region", seen.start_pos, 0);
            end else begin
                want = expected_regions.pop_front();
                if (seen.chrom !== want.chrom)
                    report_mismatch("region_chrom", seen.chrom, want.chrom);
                if (seen.start_pos !== want.start_pos)
                    report_mismatch("region_start", seen.start_pos, want.start_pos);
                if (seen.end_pos !== want.end_pos)
                    report_mismatch("region_end", seen.end_pos, want.end_pos);
                if (seen.raw_count !== want.raw_count)
                    report_mismatch("raw_significant_count", seen.raw_count,
                                    want.raw_count);
                if (seen.tcov !== want.tcov)
                    report_mismatch("test_coverage_sum", seen.tcov, want.tcov);
                if (seen.tmeth !== want.tmeth)
                    report_mismatch("test_methylated_sum", seen.tmeth, want.tmeth);
                if (seen.rcov !== want.rcov)
                    report_mismatch("rest_coverage_sum", seen.rcov, want.rcov);
                if (seen.rmeth !== want.rmeth)
                    report_mismatch("rest_methylated_sum", seen.rmeth, want.rmeth);
                if (seen.diff !== want.diff)
                    report_mismatch("level_difference", seen.diff, want.diff);
                if (seen.zero_cov !== want.zero_cov)
                    report_mismatch("zero_coverage", seen.zero_cov, want.zero_cov);
            end
        end
        if (hold_receiver) begin
            // Long receiver stall so the region queue fills and full rises.
            pop <= 0;
            if (hold_count > 0) hold_count <= hold_count - 1;
            else hold_receiver <= 0;
        end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            pop <= 0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            pop_gap <= $urandom_range(1, 11) - 1;
            pop <= 0;
        end else begin
            pop <= 1;
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("significant_site_region_merger regression: fail");
                    $finish;
                end
            end
        end
    end

    function automatic logic [31:0] rand_pvalue();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | $urandom;           // untested
            1: return {1'b0, cutoff};                     // exactly at cutoff
            2: return (cutoff == 0) ? 32'd0 : {1'b0, cutoff} - 1;
            3: return $urandom;
            default: return $urandom_range(0, cutoff);    // mostly significant
        endcase
    endfunction

    function automatic t_site rand_site(logic [7:0] chrom, logic [31:0] pos);
        t_site s;
        s.eos = 0;
        s.chrom = chrom;
        s.pos = pos;
        s.rawp = rand_pvalue();
        s.corp = ($urandom_range(0, 3) == 0) ? rand_pvalue()
                                             : $urandom_range(0, cutoff - 1);
        if (cutoff == 0) s.corp = rand_pvalue();
        s.tcov = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        s.tmeth = 16'($urandom);
        s.rcov = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
        s.rmeth = ($urandom_range(0, 3) == 0) ? s.rcov : 16'($urandom_range(0, s.rcov));
        return s;
    endfunction

    function automatic t_site end_mark();
        t_site s;
        s = SITE_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        s.eos = 1;
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_sites.size() > 0 || push || expected_regions.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cutoff(logic [30:0] value);
        cfg_valid <= 1;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cutoff = value;
        cfg_valid <= 0;
    endtask

    // A random run of chromosome groups: mostly contiguous significant
    // sites with occasional breaks, chromosome changes and stream ends.
    task automatic queue_random(int count);
        logic [7:0]  chrom;
        logic [31:0] pos;
        chrom = $urandom;
        pos = $urandom;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                pending_sites.push_back(end_mark());
            end else begin
                if ($urandom_range(0, 7) == 0) chrom = $urandom;
                pos = pos + $urandom_range(1, 300);
                pending_sites.push_back(rand_site(chrom, pos));
            end
        end
        pending_sites.push_back(end_mark());
    endtask

    initial begin
        t_site s;
        cutoff = CUTOFF_RESET;
        reg_open = 0;
        skipped = 0;
        open_reg = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: large sums, last position, zero coverage,
        // methylated above coverage, nonsignificant breaks, chromosome change.
        s = '0;
        s.chrom = 8'hFF;
        s.pos = 32'hFFFF_FFFE;
        s.tcov = 16'hFFFF; s.tmeth = 16'hFFFF; s.rcov = 16'h0; s.rmeth = 16'hFFFF;
        pending_sites.push_back(s);
        s.pos = 32'hFFFF_FFFF; s.rawp = 32'h8000_0000;
        pending_sites.push_back(s);
        s.corp = {1'b0, CUTOFF_RESET};            // not significant: a break
        pending_sites.push_back(s);
        s.corp = 32'hFFFF_FFFF;                   // untested
        pending_sites.push_back(s);
        s = '0; s.chrom = 8'h00; s.pos = 0;
        s.tcov = 10; s.tmeth = 30; s.rcov = 7; s.rmeth = 3;
        pending_sites.push_back(s);
        s.chrom = 8'h01;                          // other chromosome
        s.corp = {1'b0, CUTOFF_RESET} - 1;
        s.rawp = 32'h7FFF_FFFF;                   // not raw-significant
        pending_sites.push_back(s);
        pending_sites.push_back(end_mark());
        pending_sites.push_back(end_mark());      // nothing left to flush
        s = '0; s.rawp = 32'h7FFF_FFFF;           // region with zero raw count
        pending_sites.push_back(s);
        pending_sites.push_back(end_mark());
        // Long run on one chromosome builds a large test coverage sum.
        s = '0; s.tcov = 16'hFFFF; s.tmeth = 16'h1; s.rcov = 16'h1; s.rmeth = 16'h1;
        for (int i = 0; i < 12; i++) begin
            s.pos = i;
            pending_sites.push_back(s);
        end
        pending_sites.push_back(end_mark());
        wait_drained();

        // Lowest cutoff: nothing is significant.
        write_cutoff(31'd0);
        queue_random(30);
        wait_drained();

        // Largest cutoff, well beyond 1.0.
        write_cutoff(31'h7FFF_FFFF);
        queue_random(150);
        wait_drained();

        // Receiver stalls long while the sender keeps pushing; the queue fills.
        write_cutoff(31'd1 << 30);
        hold_count = 300;
        hold_receiver = 1;
        queue_random(150);
        wait_drained();

        // Sender has paused until all results arrived (wait_drained above).
        write_cutoff(31'd10737418 * 20);
        queue_random(150);
        wait_drained();

        // Final part at full rate on both sides.
        write_cutoff(CUTOFF_RESET);
        quiet_tail = 1;
        queue_random(150);
        wait_drained();

        if (mismatches == 0 && expected_regions.size() == 0) begin
            $display("significant_site_region_merger regression: pass");
        end else begin
            $display("significant_site_region_merger regression: fail");
        end
        $finish;
    end
endmodule
